/* hdl/nlt_pkg.sv */
// Package for the neighbour list table: opcodes, controller states and
// the fixed field widths. No dependencies; imported by neighbor_list_table.
package nlt_pkg;

  localparam int unsigned NLT_SLOTS   = 8;
  localparam int unsigned NLT_ID_BITS = 16;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned EDGE_W  = 16;
  localparam int unsigned COUNT_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } nlt_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_FIN
  } nlt_state_e;

endpackage

/* hdl/neighbor_list_table.sv */
// Neighbour list table: a compacted list of (neighbour id, edge id) pairs
// held in one synchronous memory, with a sequencer for add, remove, lookup
// and clear. Depends on nlt_pkg.
//
// Usage: an item (opcode_i, neighbor_id_i, edge_id_i) is taken when in_valid_i
// and in_ready_o are both high; one result item (status_o, found_o,
// found_edge_o, entry_count_o) follows on the out channel for every item.
// Items are handled one at a time. The memory has one registered read port,
// so the scan reads and then compares each entry it examines (ST_RD, ST_CMP),
// and a remove reads and writes each entry shifted down (ST_SH_RD, ST_SH_WR).
// Clear, add on a full list and any item on an empty list go straight from
// idle to the finish state; every other item first scans the list from slot
// zero.
// The input is ready again in the cycle in which the result appears.
// The result waits in an output register; the next item is accepted while it
// waits, and the sequencer holds its finished result if the receiver stalls.
// Reset empties the list at once; slot contents are left undefined and are
// never read beyond the entry count.
module neighbor_list_table #(
  parameter int unsigned SLOTS   = nlt_pkg::NLT_SLOTS,
  parameter int unsigned ID_BITS = nlt_pkg::NLT_ID_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [nlt_pkg::OP_W-1:0]    opcode_i,
  input  logic [nlt_pkg::ID_W-1:0]    neighbor_id_i,
  input  logic [nlt_pkg::EDGE_W-1:0]  edge_id_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        status_o,
  output logic                        found_o,
  output logic [nlt_pkg::EDGE_W-1:0]  found_edge_o,
  output logic [nlt_pkg::COUNT_W-1:0] entry_count_o
);
  import nlt_pkg::*;

  localparam int unsigned KEY_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int unsigned ENT_W = KEY_W + EDGE_W;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(SLOTS);

  nlt_state_e state_q, state_d;
  nlt_op_e    op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [EDGE_W-1:0] edge_q, edge_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic              res_status_q, res_status_d;
  logic              res_found_q, res_found_d;
  logic [EDGE_W-1:0] res_edge_q, res_edge_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_status_q, out_status_d;
  logic                 out_found_q, out_found_d;
  logic [EDGE_W-1:0]    out_edge_q, out_edge_d;
  logic [COUNT_W-1:0]   out_count_q, out_count_d;

  logic [ENT_W-1:0] slot_mem_q [SLOTS];
  logic [ENT_W-1:0] rd_data_q;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [ENT_W-1:0] mem_wdata;

  logic [KEY_W-1:0]  rd_key;
  logic [EDGE_W-1:0] rd_edge;
  logic [KEY_W-1:0]  in_key;
  logic              accept;
  logic              more;

  assign rd_key  = rd_data_q[ENT_W-1 -: KEY_W];
  assign rd_edge = rd_data_q[EDGE_W-1:0];
  assign in_key  = neighbor_id_i[KEY_W-1:0];
  assign accept  = in_valid_i && in_ready_o;
  assign more    = (CNT_W'(idx_q) + CNT_W'(1)) < count_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= slot_mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    edge_q       <= edge_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_edge_q   <= res_edge_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_edge_q   <= out_edge_d;
    out_count_q  <= out_count_d;
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    edge_d       = edge_q;
    idx_d        = idx_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_edge_d   = res_edge_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_edge_d   = out_edge_q;
    out_count_d  = out_count_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = idx_q;
    mem_raddr    = idx_q;
    mem_wdata    = rd_data_q;
    in_ready_o   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d         = nlt_op_e'(opcode_i);
          key_d        = in_key;
          edge_d       = edge_id_i;
          idx_d        = '0;
          res_status_d = 1'b0;
          res_found_d  = 1'b0;
          res_edge_d   = '0;
          state_d      = ST_FIN;
          if (nlt_op_e'(opcode_i) == OP_CLEAR) begin
            count_d = '0;
          end else if (nlt_op_e'(opcode_i) == OP_ADD && count_q >= FULL) begin
            res_status_d = 1'b1;
          end else if (count_q == '0) begin
            if (nlt_op_e'(opcode_i) == OP_ADD) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = {in_key, edge_id_i};
              count_d   = CNT_W'(1);
            end else if (nlt_op_e'(opcode_i) == OP_REMOVE) begin
              res_status_d = 1'b1;
            end
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        mem_re  = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (rd_key == key_q) begin
          case (op_q)
            OP_LOOKUP: begin
              res_found_d = 1'b1;
              res_edge_d  = rd_edge;
              state_d     = ST_FIN;
            end
            OP_REMOVE: begin
              state_d = ST_SH_RD;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end else if (more) begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_RD;
        end else begin
          state_d = ST_FIN;
          case (op_q)
            OP_ADD: begin
              mem_we    = 1'b1;
              mem_waddr = IDX_W'(count_q);
              mem_wdata = {key_q, edge_q};
              count_d   = count_q + CNT_W'(1);
            end
            OP_REMOVE: begin
              res_status_d = 1'b1;
            end
            default: begin
              res_status_d = 1'b0;
            end
          endcase
        end
      end
      ST_SH_RD: begin
        if (more) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + IDX_W'(1);
          state_d   = ST_SH_WR;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_FIN;
        end
      end
      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rd_data_q;
        idx_d     = idx_q + IDX_W'(1);
        state_d   = ST_SH_RD;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_edge_d   = res_edge_q;
          out_count_d  = COUNT_W'(count_q);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_o       = out_found_q;
  assign found_edge_o  = out_edge_q;
  assign entry_count_o = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL)
    else $error("entry count exceeds the number of slots");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && nlt_op_e'(opcode_i) == OP_CLEAR) |=> (count_q == '0))
    else $error("clear did not empty the list");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> !status_o)
    else $error("lookup hit reported with an error status");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CNT_W'(mem_waddr) < FULL))
    else $error("memory write beyond the last slot");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !out_ready_i) |=> (state_q == ST_FIN))
    else $error("finished item dropped while the receiver stalled");

endmodule
